// ===== sv/cic_mass_deposit_3d_defines.svh =====
// Assertion macros shared by the block
`ifndef CIC_MASS_DEPOSIT_3D_DEFINES_SVH
`define CIC_MASS_DEPOSIT_3D_DEFINES_SVH

// same-cycle implication
`define AST_IMP(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define AST_NEXT(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/cicmd_pkg.sv =====
`default_nettype none
package cicmd_pkg;

	// opcodes
	localparam logic [1:0] OP_DEPOSIT  = 2'd0;
	localparam logic [1:0] OP_READ     = 2'd1;
	localparam logic [1:0] OP_READ_CLR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_FULL    = 3'd0;
	localparam logic [2:0] ST_DROP    = 3'd1;
	localparam logic [2:0] ST_PARTIAL = 3'd2;
	localparam logic [2:0] ST_READ    = 3'd3;
	localparam logic [2:0] ST_SAT     = 3'd4;

	// register indexes
	localparam logic [2:0] REG_GRID_X = 3'd0;
	localparam logic [2:0] REG_GRID_Y = 3'd1;
	localparam logic [2:0] REG_GRID_Z = 3'd2;
	localparam logic [2:0] REG_INV_X  = 3'd3;
	localparam logic [2:0] REG_INV_Y  = 3'd4;
	localparam logic [2:0] REG_INV_Z  = 3'd5;
	localparam logic [2:0] REG_WRAP   = 3'd6;

	localparam logic [47:0] CELL_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [16:0] ONE_Q16  = 17'h10000;

	// effective configuration (axis sizes already clamped, 1..MAX_AXIS_CELLS)
	typedef struct packed {
		logic [8:0]  sx;
		logic [8:0]  sy;
		logic [8:0]  sz;
		logic [31:0] inv_x;
		logic [31:0] inv_y;
		logic [31:0] inv_z;
		logic        wrap;
	} cfg_t;

	// classified work handed from front to back
	typedef struct packed {
		logic [1:0]  op;
		logic        drop;
		logic [7:0]  bx;
		logic [7:0]  by;
		logic [7:0]  bz;
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fz;
		logic [31:0] mass;
		logic [14:0] idx;
	} job_t;

	// back-end status
	typedef struct packed {
		logic clearing;
		logic idle;
	} back_stat_t;

endpackage
`default_nettype wire

// ===== sv/cic_mass_deposit_3d.sv =====
`default_nettype none
// Cloud-in-cell 3D mass deposit. An item is taken when start is high and
// busy is low; its single result appears on cell_value/status for exactly
// one cycle with done high, and must be captured then (no back-pressure).
// After reset the grid memory is cleared one cell a cycle, with busy held
// high. The front end runs a multiply and an evaluate step per axis on
// the shared scaling multiplier, plus a wait per axis on the 4-bit-a-
// cycle modulo unit in periodic mode; the back end takes each of eight
// corners through states C0 to C4, a read-modify-write on the single
// grid port, and a read through RD and RDW. The front end can take a new
// item while the back end works on the last one, until the queue fills.
module cic_mass_deposit_3d #(
	parameter int MAX_AXIS_CELLS = 32,
	parameter int GRID_CELLS     = 32768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] mass,
	input  wire logic [14:0] cell_index,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic [47:0]      cell_value,
	output logic [2:0]       status
);
`include "cic_mass_deposit_3d_defines.svh"

	logic [5:0]  grid_x_q, grid_y_q, grid_z_q;
	logic [31:0] inv_x_q, inv_y_q, inv_z_q;
	logic        wrap_q;

	cicmd_pkg::cfg_t       cfg;
	cicmd_pkg::job_t       q_wdata, q_head;
	cicmd_pkg::back_stat_t bstat;
	logic                  q_push, q_pop, q_full, q_empty;
	logic                  f_busy;
	logic                  accept;

	// clamp a size register into 1..MAX_AXIS_CELLS
	function automatic logic [8:0] axis_size(input logic [5:0] g);
		logic [8:0] g9;
		g9 = {3'd0, g};
		if (g9 == 9'd0)
			return 9'd1;
		else if (int'(g9) > MAX_AXIS_CELLS)
			return 9'(MAX_AXIS_CELLS);
		else
			return g9;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= 6'd32;
			grid_y_q <= 6'd32;
			grid_z_q <= 6'd32;
			inv_x_q  <= 32'd65536;
			inv_y_q  <= 32'd65536;
			inv_z_q  <= 32'd65536;
			wrap_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cicmd_pkg::REG_GRID_X: grid_x_q <= cfg_data[5:0];
				cicmd_pkg::REG_GRID_Y: grid_y_q <= cfg_data[5:0];
				cicmd_pkg::REG_GRID_Z: grid_z_q <= cfg_data[5:0];
				cicmd_pkg::REG_INV_X:  inv_x_q  <= cfg_data;
				cicmd_pkg::REG_INV_Y:  inv_y_q  <= cfg_data;
				cicmd_pkg::REG_INV_Z:  inv_z_q  <= cfg_data;
				cicmd_pkg::REG_WRAP:   wrap_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.sx    = axis_size(grid_x_q);
		cfg.sy    = axis_size(grid_y_q);
		cfg.sz    = axis_size(grid_z_q);
		cfg.inv_x = inv_x_q;
		cfg.inv_y = inv_y_q;
		cfg.inv_z = inv_z_q;
		cfg.wrap  = wrap_q;
	end

	assign busy   = f_busy || bstat.clearing;
	assign accept = start && !busy;

	cicmd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.mass       (mass),
		.cell_index (cell_index),
		.cfg        (cfg),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata),
		.f_busy     (f_busy)
	);

	cicmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	cicmd_back #(
		.GRID_CELLS (GRID_CELLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.done       (done),
		.cell_value (cell_value),
		.status     (status),
		.stat       (bstat)
	);

	// checks
	`AST_NEXT(a_done_single, clk, arst_n, done, !done)
	`AST_IMP(a_clear_busy, clk, arst_n, bstat.clearing, busy && !done)
	`AST_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`AST_IMP(a_pop_nonempty, clk, arst_n, q_pop, !q_empty)
	`AST_NEXT(a_idle_quiet, clk, arst_n, bstat.idle, !done)

endmodule
`default_nettype wire

// ===== sv/cicmd_mod.sv =====
`default_nettype none
// Signed 32-bit value modulo a 1..256 divisor, 4 quotient bits a cycle
module cicmd_mod (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [8:0]  divisor,
	output logic             done,
	output logic [7:0]       rem
);
	logic        run_q;
	logic        done_q;
	logic [2:0]  cnt_q;
	logic [31:0] m_q;
	logic [8:0]  r_q;
	logic [8:0]  div_q;
	logic        neg_q;
	logic [9:0]  rt;
	logic [31:0] mt;

	// four restoring steps
	always_comb begin
		rt = {1'b0, r_q};
		mt = m_q;
		for (int i = 0; i < 4; i++) begin
			rt = {rt[8:0], mt[31]};
			mt = {mt[30:0], 1'b0};
			if (rt >= {1'b0, div_q})
				rt = rt - {1'b0, div_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31];
			m_q   <= dividend[31] ? (~dividend + 32'd1) : dividend;
			r_q   <= 9'd0;
			div_q <= divisor;
		end else if (run_q) begin
			m_q <= mt;
			r_q <= rt[8:0];
		end
	end

	// floor-mod fix for negative values
	assign done = done_q;
	assign rem  = (neg_q && r_q != 9'd0) ? 8'(div_q - r_q) : r_q[7:0];

endmodule
`default_nettype wire

// ===== sv/cicmd_front.sv =====
`default_nettype none
// Front end: takes items, scales positions, wraps or drops, builds jobs
module cicmd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [1:0]        opcode,
	input  wire logic [31:0]       pos_x,
	input  wire logic [31:0]       pos_y,
	input  wire logic [31:0]       pos_z,
	input  wire logic [31:0]       mass,
	input  wire logic [14:0]       cell_index,
	input  wire cicmd_pkg::cfg_t   cfg,
	input  wire logic              q_full,
	output logic                   q_push,
	output cicmd_pkg::job_t        q_data,
	output logic                   f_busy
);
	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL  = 3'd1;
	localparam logic [2:0] F_EVAL = 3'd2;
	localparam logic [2:0] F_DIV  = 3'd3;
	localparam logic [2:0] F_PUSH = 3'd4;

	logic [2:0]         state_q;
	logic [1:0]         k_q;
	logic [31:0]        pos_q [3];
	logic signed [63:0] prod_q;
	cicmd_pkg::job_t    job_q;

	logic [31:0]        pos_sel;
	logic [31:0]        inv_sel;
	logic [8:0]         size_sel;
	logic signed [63:0] prod_c;
	logic signed [31:0] base;
	logic               out_range;
	logic               mod_start;
	logic               mod_done;
	logic [7:0]         mod_rem;

	// per-axis selection
	always_comb begin
		pos_sel = pos_q[k_q];
		unique case (k_q)
			2'd0: begin
				inv_sel  = cfg.inv_x;
				size_sel = cfg.sx;
			end
			2'd1: begin
				inv_sel  = cfg.inv_y;
				size_sel = cfg.sy;
			end
			default: begin
				inv_sel  = cfg.inv_z;
				size_sel = cfg.sz;
			end
		endcase
	end

	assign prod_c    = $signed(pos_sel) * $signed({1'b0, inv_sel});
	assign base      = prod_q[63:32];
	assign out_range = (base < 0) || (base >= $signed({23'd0, size_sel}));
	assign mod_start = (state_q == F_EVAL) && cfg.wrap;

	cicmd_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (base),
		.divisor  (size_sel),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			k_q     <= 2'd0;
		end else begin
			unique case (state_q)
				F_IDLE: if (accept) begin
					k_q     <= 2'd0;
					state_q <= (opcode == cicmd_pkg::OP_DEPOSIT) ? F_MUL : F_PUSH;
				end
				F_MUL: state_q <= F_EVAL;
				F_EVAL: begin
					if (cfg.wrap)
						state_q <= F_DIV;
					else if (out_range)
						state_q <= F_PUSH;
					else if (k_q == 2'd2)
						state_q <= F_PUSH;
					else begin
						k_q     <= k_q + 2'd1;
						state_q <= F_MUL;
					end
				end
				F_DIV: if (mod_done) begin
					if (k_q == 2'd2)
						state_q <= F_PUSH;
					else begin
						k_q     <= k_q + 2'd1;
						state_q <= F_MUL;
					end
				end
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// job assembly
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			job_q.op   <= opcode;
			job_q.drop <= 1'b0;
			job_q.mass <= mass;
			job_q.idx  <= cell_index;
			pos_q[0]   <= pos_x;
			pos_q[1]   <= pos_y;
			pos_q[2]   <= pos_z;
		end
		if (state_q == F_MUL)
			prod_q <= prod_c;
		if (state_q == F_EVAL) begin
			unique case (k_q)
				2'd0: job_q.fx <= prod_q[31:16];
				2'd1: job_q.fy <= prod_q[31:16];
				default: job_q.fz <= prod_q[31:16];
			endcase
			if (!cfg.wrap) begin
				if (out_range)
					job_q.drop <= 1'b1;
				unique case (k_q)
					2'd0: job_q.bx <= base[7:0];
					2'd1: job_q.by <= base[7:0];
					default: job_q.bz <= base[7:0];
				endcase
			end
		end
		if (state_q == F_DIV && mod_done) begin
			unique case (k_q)
				2'd0: job_q.bx <= mod_rem;
				2'd1: job_q.by <= mod_rem;
				default: job_q.bz <= mod_rem;
			endcase
		end
	end

	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = job_q;
	assign f_busy = (state_q != F_IDLE);

endmodule
`default_nettype wire

// ===== sv/cicmd_queue.sv =====
`default_nettype none
// Two-entry job queue between front and back
module cicmd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire cicmd_pkg::job_t wdata,
	input  wire logic            pop,
	output cicmd_pkg::job_t      head,
	output logic                 full,
	output logic                 empty
);
	cicmd_pkg::job_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign head  = mem_q[rp_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

endmodule
`default_nettype wire

// ===== sv/cicmd_back.sv =====
`default_nettype none
// Back end: grid memory, corner read-modify-writes, reads, results
module cicmd_back #(
	parameter int GRID_CELLS = 32768
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cicmd_pkg::cfg_t cfg,
	input  wire logic            q_empty,
	input  wire cicmd_pkg::job_t q_head,
	output logic                 q_pop,
	output logic                 done,
	output logic [47:0]          cell_value,
	output logic [2:0]           status,
	output cicmd_pkg::back_stat_t stat
);
	localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam logic [26:0] GRID_LIM = 27'(GRID_CELLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(GRID_CELLS - 1);

	localparam logic [3:0] B_CLR  = 4'd0;
	localparam logic [3:0] B_IDLE = 4'd1;
	localparam logic [3:0] B_DISP = 4'd2;
	localparam logic [3:0] B_RD   = 4'd3;
	localparam logic [3:0] B_RDW  = 4'd4;
	localparam logic [3:0] B_C0   = 4'd5;
	localparam logic [3:0] B_C1   = 4'd6;
	localparam logic [3:0] B_C2   = 4'd7;
	localparam logic [3:0] B_C3   = 4'd8;
	localparam logic [3:0] B_C4   = 4'd9;

	logic [47:0]     mem [GRID_CELLS];
	logic [47:0]     rdata_q;
	logic [3:0]      state_q;
	logic [AW-1:0]   clr_q;
	logic [2:0]      c_q;
	logic            sat_q;
	cicmd_pkg::job_t job_q;
	logic [8:0]      tx_q, ty_q, tz_q;
	logic [16:0]     wx_q, wy_q, wz_q;
	logic [16:0]     w1_q, w_q;
	logic [17:0]     a1_q;
	logic [26:0]     addr_q;
	logic [32:0]     add_q;
	logic            done_q;
	logic [47:0]     cv_q;
	logic [2:0]      st_q;

	logic [8:0]      tx, ty, tz;
	logic [16:0]     wx, wy, wz;
	logic            edge_hit;
	logic [33:0]     p1, p2;
	logic [48:0]     p3;
	logic [17:0]     a1;
	logic [26:0]     a2;
	logic [48:0]     sum;
	logic            idx_ok;
	logic            addr_ok;
	logic            we;
	logic [AW-1:0]   wa;
	logic [AW-1:0]   ra;
	logic [47:0]     wd;
	logic            emit;
	logic [47:0]     emit_val;
	logic [2:0]      emit_st;

	// corner coordinates and axis weights
	always_comb begin
		tx = {1'b0, job_q.bx} + {8'd0, c_q[0]};
		ty = {1'b0, job_q.by} + {8'd0, c_q[1]};
		tz = {1'b0, job_q.bz} + {8'd0, c_q[2]};
		edge_hit = (tx == cfg.sx) || (ty == cfg.sy) || (tz == cfg.sz);
		if (tx == cfg.sx) tx = 9'd0;
		if (ty == cfg.sy) ty = 9'd0;
		if (tz == cfg.sz) tz = 9'd0;
		wx = c_q[0] ? {1'b0, job_q.fx} : cicmd_pkg::ONE_Q16 - {1'b0, job_q.fx};
		wy = c_q[1] ? {1'b0, job_q.fy} : cicmd_pkg::ONE_Q16 - {1'b0, job_q.fy};
		wz = c_q[2] ? {1'b0, job_q.fz} : cicmd_pkg::ONE_Q16 - {1'b0, job_q.fz};
	end

	assign p1 = {17'd0, wx_q} * {17'd0, wy_q};
	assign p2 = {17'd0, w1_q} * {17'd0, wz_q};
	assign p3 = {32'd0, w_q} * {17'd0, job_q.mass};
	assign a1 = 18'(tx_q) * 18'(cfg.sy) + 18'(ty_q);
	assign a2 = 27'(a1_q) * 27'(cfg.sz) + 27'(tz_q);
	assign sum = {1'b0, rdata_q} + {16'd0, add_q};
	assign idx_ok  = {12'd0, job_q.idx} < GRID_LIM;
	assign addr_ok = addr_q < GRID_LIM;

	// memory port control and result selection
	always_comb begin
		we       = 1'b0;
		wa       = clr_q;
		wd       = 48'd0;
		ra       = addr_q[AW-1:0];
		emit     = 1'b0;
		emit_val = 48'd0;
		emit_st  = cicmd_pkg::ST_FULL;
		q_pop    = (state_q == B_IDLE) && !q_empty;
		unique case (state_q)
			B_CLR: we = 1'b1;
			B_DISP: begin
				if (job_q.op == cicmd_pkg::OP_DEPOSIT) begin
					if (job_q.drop) begin
						emit    = 1'b1;
						emit_st = cicmd_pkg::ST_DROP;
					end
				end else if (job_q.op == cicmd_pkg::OP_READ ||
						job_q.op == cicmd_pkg::OP_READ_CLR) begin
					if (!idx_ok) begin
						emit    = 1'b1;
						emit_st = cicmd_pkg::ST_READ;
					end
				end else begin
					emit    = 1'b1;
					emit_st = cicmd_pkg::ST_DROP;
				end
			end
			B_RD: ra = AW'({12'd0, job_q.idx});
			B_RDW: begin
				emit     = 1'b1;
				emit_val = rdata_q;
				emit_st  = cicmd_pkg::ST_READ;
				if (job_q.op == cicmd_pkg::OP_READ_CLR) begin
					we = 1'b1;
					wa = AW'({12'd0, job_q.idx});
				end
			end
			B_C0: if (edge_hit && !cfg.wrap) begin
				emit    = 1'b1;
				emit_st = sat_q ? cicmd_pkg::ST_SAT : cicmd_pkg::ST_PARTIAL;
			end
			B_C3: if (!addr_ok && c_q == 3'd7) begin
				emit    = 1'b1;
				emit_st = sat_q ? cicmd_pkg::ST_SAT : cicmd_pkg::ST_FULL;
			end
			B_C4: begin
				we = 1'b1;
				wa = addr_q[AW-1:0];
				wd = sum[48] ? cicmd_pkg::CELL_MAX : sum[47:0];
				if (c_q == 3'd7) begin
					emit    = 1'b1;
					emit_st = (sat_q || sum[48]) ? cicmd_pkg::ST_SAT : cicmd_pkg::ST_FULL;
				end
			end
			default: ;
		endcase
	end

	// grid memory
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rdata_q <= mem[ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q   <= '0;
			c_q     <= 3'd0;
			sat_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= emit;
			unique case (state_q)
				B_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_CELL) state_q <= B_IDLE;
				end
				B_IDLE: if (!q_empty) state_q <= B_DISP;
				B_DISP: begin
					c_q   <= 3'd0;
					sat_q <= 1'b0;
					if (emit)
						state_q <= B_IDLE;
					else if (job_q.op == cicmd_pkg::OP_DEPOSIT)
						state_q <= B_C0;
					else
						state_q <= B_RD;
				end
				B_RD:  state_q <= B_RDW;
				B_RDW: state_q <= B_IDLE;
				B_C0:  state_q <= emit ? B_IDLE : B_C1;
				B_C1:  state_q <= B_C2;
				B_C2:  state_q <= B_C3;
				B_C3: begin
					if (addr_ok)
						state_q <= B_C4;
					else if (c_q == 3'd7)
						state_q <= B_IDLE;
					else begin
						c_q     <= c_q + 3'd1;
						state_q <= B_C0;
					end
				end
				B_C4: begin
					if (sum[48]) sat_q <= 1'b1;
					if (c_q == 3'd7)
						state_q <= B_IDLE;
					else begin
						c_q     <= c_q + 3'd1;
						state_q <= B_C0;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// corner datapath and result registers
	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_head;
		if (state_q == B_C0) begin
			tx_q <= tx;
			ty_q <= ty;
			tz_q <= tz;
			wx_q <= wx;
			wy_q <= wy;
			wz_q <= wz;
		end
		if (state_q == B_C1) begin
			w1_q <= p1[32:16];
			a1_q <= a1;
		end
		if (state_q == B_C2) begin
			w_q    <= p2[32:16];
			addr_q <= a2;
		end
		if (state_q == B_C3) add_q <= p3[48:16];
		if (emit) begin
			cv_q <= emit_val;
			st_q <= emit_st;
		end
	end

	assign done          = done_q;
	assign cell_value    = cv_q;
	assign status        = st_q;
	assign stat.clearing = (state_q == B_CLR);
	assign stat.idle     = (state_q == B_IDLE) && q_empty;

endmodule
`default_nettype wire
